/* sv/rth_pkg.sv */
// Package for the RGB to HSV converter: field widths and the record that
// travels down the chain of divider cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

	// Width of one color channel and of the two 16-bit results.
	localparam int CHAN_W = 8;
	localparam int Q_W    = 16;

	// Hue divisor is six times the channel span, at most 1530.
	localparam int HUE_W  = 11;

	// Saturation divisor is the largest channel.
	localparam int SAT_W  = CHAN_W;

	// Packed stream payload widths.
	localparam int IN_W   = 3 * CHAN_W;
	localparam int OUT_W  = 2 * Q_W + CHAN_W;

	// Partial state of both long divisions for one pixel.
	typedef struct packed {
		logic [HUE_W-1:0] hue_rem;
		logic [HUE_W-1:0] hue_div;
		logic [Q_W-1:0]   hue_q;
		logic [SAT_W-1:0] sat_rem;
		logic [SAT_W-1:0] sat_div;
		logic [Q_W-1:0]   sat_lo;
		logic [Q_W-1:0]   sat_q;
		logic [CHAN_W-1:0] bright;
	} rth_work_t;

endpackage

`default_nettype wire

/* sv/rth_prep.sv */
// First stage of the RGB to HSV converter: finds max, min and span and
// sets up the dividend and divisor of the hue and saturation divisions.
// Depends on rth_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rth_prep (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [rth_pkg::CHAN_W-1:0]    red,
	input  wire logic [rth_pkg::CHAN_W-1:0]    green,
	input  wire logic [rth_pkg::CHAN_W-1:0]    blue,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output rth_pkg::rth_work_t                 out_work
);

	logic [rth_pkg::CHAN_W-1:0] rg_max, rg_min, hi, lo, delta;
	logic signed [11:0]         d_s, num_raw, num;
	logic [rth_pkg::HUE_W-1:0]  d6;
	logic [23:0]                sat_num;
	rth_pkg::rth_work_t         work_d, work_q;
	logic                       valid_q;

	// Largest, smallest and span of the three channels.
	always_comb begin
		rg_max = (red > green) ? red : green;
		rg_min = (red < green) ? red : green;
		hi     = (rg_max > blue) ? rg_max : blue;
		lo     = (rg_min < blue) ? rg_min : blue;
		delta  = hi - lo;
	end

	// Hue numerator by sector, wrapped to stay nonnegative.
	always_comb begin
		d_s = $signed({4'b0000, delta});
		d6  = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
		if (red == hi) begin
			num_raw = $signed({4'b0000, green}) - $signed({4'b0000, blue});
		end else if (green == hi) begin
			num_raw = (d_s <<< 1) + $signed({4'b0000, blue}) - $signed({4'b0000, red});
		end else begin
			num_raw = (d_s <<< 2) + $signed({4'b0000, red}) - $signed({4'b0000, green});
		end
		if (num_raw < 0) begin
			num = num_raw + $signed({1'b0, d6});
		end else begin
			num = num_raw;
		end
	end

	// Saturation dividend is delta * 65535; a zero divisor becomes one so
	// the zero dividend gives a zero quotient.
	always_comb begin
		sat_num          = {delta, 16'h0000} - {16'h0000, delta};
		work_d.hue_rem   = num[rth_pkg::HUE_W-1:0];
		work_d.hue_div   = (delta == '0) ? rth_pkg::HUE_W'(1) : d6;
		work_d.hue_q     = '0;
		work_d.sat_rem   = sat_num[23:16];
		work_d.sat_div   = (hi == '0) ? rth_pkg::SAT_W'(1) : hi;
		work_d.sat_lo    = sat_num[15:0];
		work_d.sat_q     = '0;
		work_d.bright    = hi;
	end

	// Stage handshake: load whenever the register is empty or drains.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

`default_nettype wire

/* sv/rth_cell.sv */
// One cell of the divider chain: retires one quotient bit of the hue and
// of the saturation restoring divisions and hands the record on.
// Depends on rth_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rth_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire rth_pkg::rth_work_t in_work,
	output logic              out_valid,
	input  wire logic         out_ready,
	output rth_pkg::rth_work_t out_work
);

	logic [rth_pkg::HUE_W:0]  hue_t;
	logic [rth_pkg::SAT_W:0]  sat_t;
	logic                     hue_bit, sat_bit;
	rth_pkg::rth_work_t       work_d, work_q;
	logic                     valid_q;

	// Shift the remainder, try the subtraction, keep it if it fits.
	always_comb begin
		work_d  = in_work;
		hue_t   = {in_work.hue_rem, 1'b0};
		sat_t   = {in_work.sat_rem, in_work.sat_lo[rth_pkg::Q_W-1]};
		hue_bit = (hue_t >= {1'b0, in_work.hue_div});
		sat_bit = (sat_t >= {1'b0, in_work.sat_div});
		if (hue_bit) begin
			hue_t = hue_t - {1'b0, in_work.hue_div};
		end
		if (sat_bit) begin
			sat_t = sat_t - {1'b0, in_work.sat_div};
		end
		work_d.hue_rem = hue_t[rth_pkg::HUE_W-1:0];
		work_d.hue_q   = {in_work.hue_q[rth_pkg::Q_W-2:0], hue_bit};
		work_d.sat_rem = sat_t[rth_pkg::SAT_W-1:0];
		work_d.sat_lo  = {in_work.sat_lo[rth_pkg::Q_W-2:0], 1'b0};
		work_d.sat_q   = {in_work.sat_q[rth_pkg::Q_W-2:0], sat_bit};
	end

	// Stage handshake: load whenever the register is empty or drains.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

`default_nettype wire

/* sv/rgb_to_hsv_core.sv */
// RGB to HSV converter, top level: a setup stage followed by a chain of
// sixteen divider cells. Depends on rth_pkg, rth_prep and rth_cell.
//
// Usage: one pixel per transaction on the s_axis channel, tdata holding
// red in bits 7:0, green in 15:8 and blue in 23:16. Each pixel gives one
// transaction on the m_axis channel with hue in bits 15:0 (1/65536 turn),
// saturation in 31:16 and brightness (largest channel) in 39:32.
// The path from input to output is one setup stage plus one cell per
// quotient bit, the two divisions running side by side.
// Throughput is one pixel per clock; every stage is a register with its
// own valid bit, so the chain takes a new pixel each cycle it can advance.
// When the receiver stalls, the full stages nearest the output hold while
// empty stages further up keep filling; s_axis_tready drops only once the
// stages between the input and the stalled output are all full.
// Reset clears every valid bit; pixel data in flight is discarded.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [rth_pkg::IN_W-1:0]    s_axis_tdata,  // red, green, blue
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [rth_pkg::OUT_W-1:0]        m_axis_tdata   // hue, saturation, brightness
);

	localparam int NCELL = rth_pkg::Q_W;

	logic               valid_c [NCELL+1];
	logic               ready_c [NCELL+1];
	rth_pkg::rth_work_t work_c  [NCELL+1];

	// Setup stage.
	rth_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.red       (s_axis_tdata[rth_pkg::CHAN_W-1:0]),
		.green     (s_axis_tdata[2*rth_pkg::CHAN_W-1:rth_pkg::CHAN_W]),
		.blue      (s_axis_tdata[3*rth_pkg::CHAN_W-1:2*rth_pkg::CHAN_W]),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_work  (work_c[0])
	);

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rth_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_work   (work_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_work  (work_c[i+1])
		);
	end

	// Output transaction straight from the last cell.
	assign ready_c[NCELL] = m_axis_tready;
	assign m_axis_tvalid  = valid_c[NCELL];
	assign m_axis_tdata   = {work_c[NCELL].bright, work_c[NCELL].sat_q, work_c[NCELL].hue_q};

`ifndef NO_ASSERTIONS
	// The input can only be blocked by a result held at the output.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a held output");

	// A black pixel has no saturation.
	a_black_unsaturated: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[39:32] == 8'h00)) |-> (m_axis_tdata[31:16] == 16'h0000))
		else $error("nonzero saturation for a black pixel");

	// A grey pixel has zero hue.
	a_grey_no_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[31:16] == 16'h0000)) |-> (m_axis_tdata[15:0] == 16'h0000))
		else $error("nonzero hue for a grey pixel");
`endif

endmodule

`default_nettype wire
